[src/xxh32_pkg.sv]
package xxh32_pkg;

  // xxhash32 primes
  localparam logic [31:0] P1 = 32'd2654435761;
  localparam logic [31:0] P2 = 32'd2246822519;
  localparam logic [31:0] P3 = 32'd3266489917;
  localparam logic [31:0] P4 = 32'd668265263;
  localparam logic [31:0] P5 = 32'd374761393;

  // lane start offsets relative to the seed
  localparam logic [31:0] LANE0_OFS = 32'(P1 + P2);
  localparam logic [31:0] LANE1_OFS = P2;
  localparam logic [31:0] LANE3_OFS = 32'(32'd0 - P1);

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_APPEND,
    OP_ABS_MUL,
    OP_ABS_ADD,
    OP_ABS_STO,
    OP_FIN1,
    OP_FIN2,
    OP_W_MUL,
    OP_W_ADD,
    OP_W_STO,
    OP_B_MUL,
    OP_B_ADD,
    OP_B_STO,
    OP_AV1,
    OP_AV2,
    OP_DONE
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;    // buffer holds 15 bytes
    logic lane_last;   // lane index at lane 3
    logic words_left;  // a 4-byte word remains in the tail
    logic bytes_left;  // at least one byte remains in the tail
    logic out_free;    // output register can take a digest
  } sts_t;

  function automatic logic [31:0] rotl32(logic [31:0] x, int unsigned n);
    rotl32 = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] bswap32(logic [31:0] x);
    bswap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

[src/xxh32_ctrl.sv]
module xxh32_ctrl
  import xxh32_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic action_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_ABS_MUL = 14'b00000000000010,
    S_ABS_ADD = 14'b00000000000100,
    S_ABS_STO = 14'b00000000001000,
    S_FIN2    = 14'b00000000010000,
    S_SEL     = 14'b00000000100000,
    S_W_MUL   = 14'b00000001000000,
    S_W_ADD   = 14'b00000010000000,
    S_W_STO   = 14'b00000100000000,
    S_B_MUL   = 14'b00001000000000,
    S_B_ADD   = 14'b00010000000000,
    S_B_STO   = 14'b00100000000000,
    S_AV      = 14'b01000000000000,
    S_DONE    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   av2_q, av2_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    av2_d      = av2_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (action_i) begin
            cmd_o.op = OP_FIN1;
            state_d  = S_FIN2;
          end else begin
            cmd_o.op = OP_APPEND;
            if (sts_i.cnt_last) state_d = S_ABS_MUL;
          end
        end
      end
      S_ABS_MUL: begin
        cmd_o.op = OP_ABS_MUL;
        state_d  = S_ABS_ADD;
      end
      S_ABS_ADD: begin
        cmd_o.op = OP_ABS_ADD;
        state_d  = S_ABS_STO;
      end
      S_ABS_STO: begin
        cmd_o.op = OP_ABS_STO;
        state_d  = sts_i.lane_last ? S_IDLE : S_ABS_MUL;
      end
      S_FIN2: begin
        cmd_o.op = OP_FIN2;
        state_d  = S_SEL;
      end
      S_SEL: begin
        if (sts_i.words_left) begin
          state_d = S_W_MUL;
        end else if (sts_i.bytes_left) begin
          state_d = S_B_MUL;
        end else begin
          state_d = S_AV;
          av2_d   = 1'b0;
        end
      end
      S_W_MUL: begin
        cmd_o.op = OP_W_MUL;
        state_d  = S_W_ADD;
      end
      S_W_ADD: begin
        cmd_o.op = OP_W_ADD;
        state_d  = S_W_STO;
      end
      S_W_STO: begin
        cmd_o.op = OP_W_STO;
        state_d  = S_SEL;
      end
      S_B_MUL: begin
        cmd_o.op = OP_B_MUL;
        state_d  = S_B_ADD;
      end
      S_B_ADD: begin
        cmd_o.op = OP_B_ADD;
        state_d  = S_B_STO;
      end
      S_B_STO: begin
        cmd_o.op = OP_B_STO;
        state_d  = S_SEL;
      end
      // two avalanche multiply steps
      S_AV: begin
        if (av2_q) begin
          cmd_o.op = OP_AV2;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_AV1;
          av2_d    = 1'b1;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_DONE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      av2_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      av2_q   <= av2_d;
    end
  end

endmodule

[src/xxh32_dp.sv]
module xxh32_dp
  import xxh32_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [7:0]  data_byte_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_seed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_o
);

  logic [31:0]           seed_q;
  logic [31:0]           lane_q [4];
  logic [3:0][7:0]       buf_q  [4];
  logic [3:0]            cnt_q;
  logic [63:0]           len_q;
  logic [3:0]            idx_q;
  logic [31:0]           h_q;
  logic [31:0]           x_q;
  logic                  out_valid_q;
  logic [31:0]           digest_q;

  logic [1:0]            waddr;
  logic [3:0][7:0]       word_rd;
  logic [31:0]           word_val;
  logic [7:0]            byte_rd;
  logic [31:0]           mul_a;
  logic [31:0]           mul_k;
  logic [31:0]           prod;
  logic [31:0]           add_base;
  logic [31:0]           add_sum;
  logic                  long_msg;
  logic [31:0]           fin1_val;
  logic [31:0]           fin2_val;
  logic [31:0]           mix_fin;
  logic                  out_free;

  // buffer read port: lane word during absorb, tail word or byte at finish
  assign waddr    = (cmd_i.op == OP_ABS_MUL) ? idx_q[1:0] : idx_q[3:2];
  assign word_rd  = buf_q[waddr];
  assign word_val = word_rd;
  assign byte_rd  = word_rd[idx_q[1:0]];

  // shared multiplier operand select
  always_comb begin
    mul_a = x_q;
    mul_k = P1;
    case (cmd_i.op)
      OP_ABS_MUL: begin
        mul_a = word_val;
        mul_k = P2;
      end
      OP_ABS_STO: begin
        mul_a = x_q;
        mul_k = P1;
      end
      OP_W_MUL: begin
        mul_a = word_val;
        mul_k = P3;
      end
      OP_W_STO: begin
        mul_a = x_q;
        mul_k = P4;
      end
      OP_B_MUL: begin
        mul_a = {24'd0, byte_rd};
        mul_k = P5;
      end
      OP_B_STO: begin
        mul_a = x_q;
        mul_k = P1;
      end
      OP_AV1: begin
        mul_a = h_q ^ (h_q >> 15);
        mul_k = P2;
      end
      OP_AV2: begin
        mul_a = x_q ^ (x_q >> 13);
        mul_k = P3;
      end
      default: begin
        mul_a = x_q;
        mul_k = P1;
      end
    endcase
  end

  assign prod = 32'(mul_a * mul_k);

  // add ahead of the rotate
  assign add_base = (cmd_i.op == OP_ABS_ADD) ? lane_q[idx_q[1:0]] : h_q;
  assign add_sum  = add_base + x_q;

  // lane fold at finish
  assign long_msg = |len_q[63:4];
  assign fin1_val = len_q[31:0] + (long_msg ? (rotl32(lane_q[0], 1) + rotl32(lane_q[1], 7))
                                            : (lane_q[2] + P5));
  assign fin2_val = h_q + (long_msg ? (rotl32(lane_q[2], 12) + rotl32(lane_q[3], 18))
                                    : 32'd0);
  assign mix_fin  = x_q ^ (x_q >> 16);

  assign out_free = !out_valid_q || out_ready_i;

  // status toward the controller
  assign sts_o.cnt_last   = (cnt_q == 4'd15);
  assign sts_o.lane_last  = (idx_q[1:0] == 2'd3);
  assign sts_o.words_left = ({1'b0, idx_q} + 5'd4) <= {1'b0, cnt_q};
  assign sts_o.bytes_left = (idx_q < cnt_q);
  assign sts_o.out_free   = out_free;

  // message byte buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_APPEND) begin
      buf_q[cnt_q[3:2]][cnt_q[1:0]] <= data_byte_i;
    end
  end

  // seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_seed_i;
    end
  end

  // lanes, count, length and index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q[0] <= LANE0_OFS;
      lane_q[1] <= LANE1_OFS;
      lane_q[2] <= '0;
      lane_q[3] <= LANE3_OFS;
      cnt_q     <= '0;
      len_q     <= '0;
      idx_q     <= '0;
    end else begin
      case (cmd_i.op)
        OP_APPEND: begin
          cnt_q <= cnt_q + 4'd1;
          len_q <= len_q + 64'd1;
          idx_q <= '0;
        end
        OP_ABS_STO: begin
          lane_q[idx_q[1:0]] <= prod;
          idx_q              <= idx_q + 4'd1;
        end
        OP_FIN1: idx_q <= '0;
        OP_W_STO: idx_q <= idx_q + 4'd4;
        OP_B_STO: idx_q <= idx_q + 4'd1;
        OP_DONE: begin
          lane_q[0] <= seed_q + LANE0_OFS;
          lane_q[1] <= seed_q + LANE1_OFS;
          lane_q[2] <= seed_q;
          lane_q[3] <= seed_q + LANE3_OFS;
          cnt_q     <= '0;
          len_q     <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers of the finish and absorb sequences
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ABS_MUL, OP_W_MUL, OP_B_MUL, OP_AV1, OP_AV2: x_q <= prod;
      OP_ABS_ADD: x_q <= rotl32(add_sum, 13);
      OP_W_ADD:   x_q <= rotl32(add_sum, 17);
      OP_B_ADD:   x_q <= rotl32(add_sum, 11);
      OP_W_STO, OP_B_STO: h_q <= prod;
      OP_FIN1:    h_q <= fin1_val;
      OP_FIN2:    h_q <= fin2_val;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_DONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DONE) begin
      digest_q <= bswap32(mix_fin);
    end
  end

  assign out_valid_o = out_valid_q;
  assign digest_o    = digest_q;

endmodule

[src/xxhash32_stream.sv]
// xxhash32_stream: 32-bit xxHash over a byte stream, one byte per item.
// Input channel (in_valid_i/in_ready_o) carries action_i and data_byte_i:
// action 0 appends data_byte_i to the message, action 1 closes the message
// and produces one digest on the output channel (out_valid_o/out_ready_i).
// The seed is written on its own channel (cfg_valid_i/cfg_ready_o, seed_i);
// the user must write it only while the block is idle, which the block
// itself does not enforce. It takes effect at the next finish. The append
// that fills a 16-byte block is followed by lane updates (four lanes, three
// steps each through the one shared multiplier), during which in_ready_o is low.
// A finish works through the tail words plus tail bytes left in the buffer
// (0 to 6 of them) on its way to the digest; each tail word or byte goes
// through multiply, add and rotate, multiply, then select.
// The digest sits in an output register, so the next message can start
// while it waits; a finish that completes while the receiver still stalls
// holds in its last step until the register frees.
// Reset clears the seed to zero, loads the lanes from that seed and empties
// the message.
module xxhash32_stream
  import xxh32_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] seed_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer
  xxh32_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // lanes, buffer and hash arithmetic
  xxh32_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_seed_i  (seed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .digest_o    (digest_o)
  );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  // xxhash32 primes
  localparam logic [31:0] PRIME1 = 32'd2654435761;
  localparam logic [31:0] PRIME2 = 32'd2246822519;
  localparam logic [31:0] PRIME3 = 32'd3266489917;
  localparam logic [31:0] PRIME4 = 32'd668265263;
  localparam logic [31:0] PRIME5 = 32'd374761393;

  localparam bit ACT_APPEND = 1'b0;
  localparam bit ACT_FINISH = 1'b1;

  localparam int unsigned N_PHASES    = 7;
  localparam int unsigned PHASE_ITEMS = 85;
  localparam int unsigned SETTLE      = 40;    // covers a lane update or a full finish
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned QUIET_LIMIT = 5000;

  // running xxhash32 of the message stream, plus the digests still owed
  class digest_board;
    logic [31:0] seed;
    logic [31:0] lane[4];
    logic [7:0]  blk[16];
    int unsigned fill;
    logic [63:0] msg_len;
    logic [31:0] owed_q[$];
    int unsigned n_msgs, n_long, n_checked, n_errors, n_seeds;

    function new();
      seed = '0;
      foreach (blk[i]) blk[i] = '0;
      reload();
    endfunction

    function logic [31:0] rol(logic [31:0] x, int unsigned n);
      logic [63:0] t;
      t = {x, x} << n;
      return t[63:32];
    endfunction

    function logic [31:0] word_at(int unsigned pos);
      return {blk[pos + 3], blk[pos + 2], blk[pos + 1], blk[pos]};
    endfunction

    // lanes restart from the stored seed, message empties
    function void reload();
      lane[0] = seed + PRIME1 + PRIME2;
      lane[1] = seed + PRIME2;
      lane[2] = seed;
      lane[3] = seed - PRIME1;
      fill = 0;
      msg_len = '0;
    endfunction

    function void set_seed(logic [31:0] s);
      seed = s;
      n_seeds++;
    endfunction

    function logic [31:0] closing_digest();
      logic [31:0] h;
      int unsigned pos;
      h = msg_len[31:0];
      if (msg_len >= 64'd16)
        h += rol(lane[0], 1) + rol(lane[1], 7) + rol(lane[2], 12) + rol(lane[3], 18);
      else
        h += lane[2] + PRIME5;
      pos = 0;
      // tail words, then tail bytes
      while (pos + 4 <= fill) begin
        h = rol(h + word_at(pos) * PRIME3, 17) * PRIME4;
        pos += 4;
      end
      while (pos < fill) begin
        h = rol(h + {24'd0, blk[pos]} * PRIME5, 11) * PRIME1;
        pos++;
      end
      // avalanche
      h ^= h >> 15;
      h *= PRIME2;
      h ^= h >> 13;
      h *= PRIME3;
      h ^= h >> 16;
      return {h[7:0], h[15:8], h[23:16], h[31:24]};
    endfunction

    function void note_item(bit act, logic [7:0] b);
      if (act == ACT_APPEND) begin
        blk[fill] = b;
        msg_len++;
        fill++;
        // full block folds into the lanes
        if (fill == 16) begin
          for (int i = 0; i < 4; i++)
            lane[i] = rol(lane[i] + word_at(4 * i) * PRIME2, 13) * PRIME1;
          fill = 0;
        end
      end else begin
        n_msgs++;
        if (msg_len >= 64'd16) n_long++;
        owed_q.push_back(closing_digest());
        reload();
      end
    endfunction

    function void check_digest(logic [31:0] got);
      logic [31:0] want;
      if (owed_q.size() == 0) begin
        n_errors++;
        $display("%0t: digest %08h arrived with none expected", $time, got);
        return;
      end
      want = owed_q.pop_front();
      n_checked++;
      if (got !== want) begin
        n_errors++;
        $display("%0t: digest mismatch, expected %08h, actual %08h", $time, want, got);
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] seed;

  digest_board board = new();

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_cycles  = 0;
  int unsigned n_items      = 0;
  int unsigned quiet        = 0;

  xxhash32_stream dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .digest_o    (digest),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .seed_i      (seed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: long hold-off on request, otherwise random stalls
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // digest check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_digest(digest);
  end

  // watchdog on cycles with no item moving on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  task automatic send_item(input bit act, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    board.note_item(act, b);
    n_items++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(ACT_APPEND, 8'($urandom_range(255)));
    send_item(ACT_FINISH, 8'($urandom_range(255)));
  endtask

  // stop sending, let every digest come out and the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] s);
    cfg_valid <= 1'b1;
    seed      <= s;
    do @(posedge clk); while (!cfg_ready);
    board.set_seed(s);
    cfg_valid <= 1'b0;
  endtask

  // mostly short messages, some spanning a few blocks, a few long ones
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(20);
    if (r < 95) return $urandom_range(48, 16);
    return $urandom_range(80, 60);
  endfunction

  initial begin
    logic [31:0] seed_plan[N_PHASES];
    int unsigned start;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    action    = 1'b0;
    data_byte = '0;
    cfg_valid = 1'b0;
    seed      = '0;
    seed_plan = '{32'h0000_0000, $urandom(), 32'h0000_0001, 32'h8000_0000,
                  $urandom(), 32'hFFFF_FFFF, $urandom()};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: new seed waits for the next finish, empty messages,
    // single byte, one tail word, one full block
    write_seed(32'hFFFF_FFFF);
    send_item(ACT_FINISH, 8'h00);
    send_item(ACT_FINISH, 8'hFF);
    send_item(ACT_APPEND, 8'hFF);
    send_item(ACT_FINISH, 8'h5A);
    send_item(ACT_APPEND, 8'h00);
    send_item(ACT_APPEND, 8'h80);
    send_item(ACT_APPEND, 8'h7F);
    send_item(ACT_APPEND, 8'hFF);
    send_item(ACT_FINISH, 8'h00);
    for (int i = 0; i < 16; i++) send_item(ACT_APPEND, (i % 2) ? 8'hFF : 8'h00);
    send_item(ACT_FINISH, 8'h00);

    // random phases, each with its own seed and idle mix
    for (int unsigned p = 0; p < N_PHASES; p++) begin
      drain();
      write_seed(seed_plan[p]);
      case (p % 4)
        0: begin
          tx_idle_pct = 0;  rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 52; rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;  rx_stall_pct = 52;
        end
        default: begin
          tx_idle_pct = 15; rx_stall_pct = 15;
        end
      endcase
      // receiver blocks while short messages pile up behind the output
      if (p == 2) hold_cycles = HOLD_LEN;
      start = n_items;
      while (n_items - start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 10) begin
          // burst with random actions: back-to-back finishes, empty messages
          repeat (8) send_item(bit'($urandom_range(1)), 8'($urandom_range(255)));
        end else if (p == 2 && hold_cycles > 0) begin
          send_message($urandom_range(3));
        end else begin
          send_message(pick_len());
        end
      end
      // sometimes leave a message open across the seed change
      if ($urandom_range(1))
        repeat ($urandom_range(20, 1)) send_item(ACT_APPEND, 8'($urandom_range(255)));
    end
    send_item(ACT_FINISH, 8'h00);

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    drain();

    $display("covered %0d items, %0d messages (%0d of 16 bytes or more), %0d digests checked",
             n_items, board.n_msgs, board.n_long, board.n_checked);
    $display("%0d seed writes, idle and stall mixes, one %0d-cycle receiver hold-off",
             board.n_seeds, HOLD_LEN);
    if (board.n_errors == 0 && board.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
